/* hw/rtl/hsl2rgb_pkg.sv */
// Shared widths, hue constants and the hue ramp weight for the HSL to RGB converter.
package hsl2rgb_pkg;

  localparam int HUE_W  = 16;  // hue field, and the split point of the ramp product
  localparam int SAT_W  = 17;  // saturation and lightness fields
  localparam int BYTE_W = 8;   // one color channel
  localparam int T3_W   = 18;  // hue argument in units of 1/(3*2^16) turn
  localparam int WT_W   = 17;  // ramp weight, 2^16 means 1.0

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [T3_W-1:0]   t3_t;
  typedef logic [WT_W-1:0]   weight_t;

  // hue argument thresholds
  localparam t3_t T3_SIXTH      = 18'd32768;   // 1/6 turn
  localparam t3_t T3_THIRD      = 18'd65536;   // 1/3 turn
  localparam t3_t T3_HALF       = 18'd98304;   // 1/2 turn
  localparam t3_t T3_TWO_THIRDS = 18'd131072;  // 2/3 turn
  localparam t3_t T3_TURN       = 18'd196608;  // one full turn

  localparam weight_t WT_ONE = 17'd65536;

  // Piecewise hue ramp: rising to 1/6, flat to 1/2, falling to 2/3, zero after.
  function automatic weight_t hue_weight(input t3_t t3);
    t3_t fall;
    fall = T3_TWO_THIRDS - t3;
    priority if (t3 < T3_SIXTH) begin
      return WT_W'({t3, 1'b0});
    end else if (t3 < T3_HALF) begin
      return WT_ONE;
    end else if (t3 < T3_TWO_THIRDS) begin
      return WT_W'({fall, 1'b0});
    end else begin
      return '0;
    end
  endfunction

endpackage

/* hw/rtl/hsl_to_rgb_converter.sv */
// Top level of the HSL to RGB converter: five-stage pipeline with valid/ready beats.
//
// Takes one pixel beat per clock while the output is not stalled and returns one RGB
// beat per input beat, in order. The pipeline stages are: clamp and l*s product,
// q/p/d and hue weights, split d*w multiply, ramp accumulation, and the 255x scale
// into the output register. The whole pipeline advances together; in_ready is low
// only while a finished result sits in the output register and out_ready is low.
// Saturation and lightness use FRAC_BITS fraction bits; zero saturation returns the
// grey level floor(255*lightness) on all three channels.
module hsl_to_rgb_converter #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [hsl2rgb_pkg::HUE_W-1:0]   hue,
  input  logic [hsl2rgb_pkg::SAT_W-1:0]   saturation,
  input  logic [hsl2rgb_pkg::SAT_W-1:0]   lightness,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [hsl2rgb_pkg::BYTE_W-1:0]  red,
  output logic [hsl2rgb_pkg::BYTE_W-1:0]  green,
  output logic [hsl2rgb_pkg::BYTE_W-1:0]  blue
);
  import hsl2rgb_pkg::*;

  localparam int CW  = (FRAC_BITS + 1 > SAT_W) ? FRAC_BITS + 1 : SAT_W;
  localparam int QW  = 2*FRAC_BITS + 1;
  localparam int GW  = CW + BYTE_W;
  localparam int T3X = T3_W + 1;
  localparam int DEPTH = 5;
  localparam logic [CW-1:0] ONE  = CW'(1) << FRAC_BITS;
  localparam logic [CW-1:0] HALF = CW'(1) << (FRAC_BITS - 1);

  logic             en;
  logic [DEPTH-1:0] stage_valid;

  // stage 1 logic
  logic [CW-1:0]   s_c, l_c;
  logic [2*CW-1:0] ls_full;
  logic [GW-1:0]   grey_sum, grey_sh;
  byte_t           grey;
  t3_t             g3, r3, b3;
  logic [T3X-1:0]  r3_sum;

  // stage 1 registers
  logic          s1_zero, s1_low;
  logic [CW-1:0] s1_l, s1_s;
  logic [QW-1:0] s1_ls;
  byte_t         s1_grey;
  t3_t           s1_t3 [3];

  // stage 2 logic and registers
  logic [QW:0]   lsh, ssh, ls2, q_w, p_w;
  logic [QW-1:0] q, p;
  logic [QW-1:0] s2_p, s2_d;
  weight_t       s2_w [3];

  // grey bypass, carried from stage 2 to the output
  logic  zero_pipe [DEPTH-1];
  byte_t grey_pipe [DEPTH-1];

  byte_t ramp_out [3];

  assign en       = !stage_valid[DEPTH-1] || out_ready;
  assign in_ready = en;
  assign out_valid = stage_valid[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (en) begin
      stage_valid <= {stage_valid[DEPTH-2:0], in_valid};
    end
  end

  // ---- stage 1: clamp, l*s, grey level, hue arguments ----
  assign s_c = (CW'(saturation) > ONE) ? ONE : CW'(saturation);
  assign l_c = (CW'(lightness) > ONE) ? ONE : CW'(lightness);
  assign ls_full = s_c * l_c;

  assign grey_sum = {l_c, {BYTE_W{1'b0}}} - GW'(l_c);
  assign grey_sh  = grey_sum >> FRAC_BITS;
  assign grey     = (grey_sh > GW'(255)) ? '1 : grey_sh[BYTE_W-1:0];

  assign g3     = T3_W'({hue, 1'b0}) + T3_W'(hue);
  assign r3_sum = T3X'(g3) + T3X'(T3_THIRD);
  assign r3     = (r3_sum > T3X'(T3_TURN)) ? T3_W'(r3_sum - T3X'(T3_TURN))
                                           : r3_sum[T3_W-1:0];
  assign b3     = (g3 >= T3_THIRD) ? g3 - T3_THIRD : g3 + T3_TWO_THIRDS;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_zero  <= (saturation == '0);
      s1_low   <= (l_c < HALF);
      s1_l     <= l_c;
      s1_s     <= s_c;
      s1_ls    <= QW'(ls_full);
      s1_grey  <= grey;
      s1_t3[0] <= r3;
      s1_t3[1] <= g3;
      s1_t3[2] <= b3;
    end
  end

  // ---- stage 2: q, p, d and ramp weights ----
  assign lsh = (QW+1)'(s1_l) << FRAC_BITS;
  assign ssh = (QW+1)'(s1_s) << FRAC_BITS;
  assign ls2 = (QW+1)'(s1_ls);
  assign q_w = s1_low ? lsh + ls2 : lsh + ssh - ls2;
  assign p_w = (lsh << 1) - q_w;
  assign q   = QW'(q_w);
  assign p   = QW'(p_w);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_p <= p;
      s2_d <= q - p;
      for (int i = 0; i < 3; i++) begin
        s2_w[i] <= hue_weight(s1_t3[i]);
      end
      zero_pipe[0] <= s1_zero;
      grey_pipe[0] <= s1_grey;
      for (int k = 1; k < DEPTH-1; k++) begin
        zero_pipe[k] <= zero_pipe[k-1];
        grey_pipe[k] <= grey_pipe[k-1];
      end
    end
  end

  // ---- stages 3 to 5: one ramp unit per channel ----
  for (genvar c = 0; c < 3; c++) begin : g_chan
    hsl2rgb_ramp #(
      .FRAC_BITS(FRAC_BITS)
    ) u_ramp (
      .clk  (clk),
      .en   (en),
      .p    (s2_p),
      .d    (s2_d),
      .w    (s2_w[c]),
      .value(ramp_out[c])
    );
  end

  assign red   = zero_pipe[DEPTH-2] ? grey_pipe[DEPTH-2] : ramp_out[0];
  assign green = zero_pipe[DEPTH-2] ? grey_pipe[DEPTH-2] : ramp_out[1];
  assign blue  = zero_pipe[DEPTH-2] ? grey_pipe[DEPTH-2] : ramp_out[2];

endmodule

/* hw/rtl/hsl2rgb_ramp.sv */
// One color channel: scales the hue ramp into p..q and reduces it to a byte (three stages).
module hsl2rgb_ramp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [2*FRAC_BITS:0]         p,
  input  logic [2*FRAC_BITS:0]         d,
  input  hsl2rgb_pkg::weight_t         w,
  output hsl2rgb_pkg::byte_t           value
);
  import hsl2rgb_pkg::*;

  localparam int QW   = 2*FRAC_BITS + 1;
  localparam int DHW  = QW - HUE_W;
  localparam int LO_W = HUE_W + WT_W;
  localparam int HI_W = DHW + WT_W;
  localparam int SW   = ((HI_W > QW) ? HI_W : QW) + 2;
  localparam int RW   = HUE_W + BYTE_W;
  localparam int VW   = QW + BYTE_W + 1;
  localparam int OW   = VW - 2*FRAC_BITS;

  // stage 3: split product d*w
  logic [LO_W-1:0] lo3;
  logic [HI_W-1:0] hi3;
  logic [QW-1:0]   p3;
  // stage 4: integer part and remainder of p + d*w/2^16
  logic [QW-1:0]    a4;
  logic [HUE_W-1:0] r4;
  logic [SW-1:0]    a_sum;
  // stage 5 arithmetic
  logic [RW-1:0]     ry;
  logic [BYTE_W-1:0] y;
  logic [VW-1:0]     vs;
  logic [OW-1:0]     vb;

  always_ff @(posedge clk) begin
    if (en) begin
      lo3 <= LO_W'(d[HUE_W-1:0]) * LO_W'(w);
      hi3 <= HI_W'(d[QW-1:HUE_W]) * HI_W'(w);
      p3  <= p;
    end
  end

  assign a_sum = SW'(p3) + SW'(hi3) + SW'(lo3[LO_W-1:HUE_W]);

  always_ff @(posedge clk) begin
    if (en) begin
      a4 <= QW'(a_sum);
      r4 <= lo3[HUE_W-1:0];
    end
  end

  // 255*x as a shift and subtract
  assign ry = {r4, {BYTE_W{1'b0}}} - RW'(r4);
  assign y  = ry[RW-1:HUE_W];
  assign vs = VW'({a4, {BYTE_W{1'b0}}}) - VW'(a4) + VW'(y);
  assign vb = vs[VW-1:2*FRAC_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      value <= (vb > OW'(255)) ? '1 : vb[BYTE_W-1:0];
    end
  end

endmodule

/* hw/rtl/hsl2rgb_checker.sv */
// Port-level checks on the HSL to RGB converter, bound to the top level.
module hsl2rgb_port_checks (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [hsl2rgb_pkg::BYTE_W-1:0]  red,
  input logic [hsl2rgb_pkg::BYTE_W-1:0]  green,
  input logic [hsl2rgb_pkg::BYTE_W-1:0]  blue
);

  // a stalled result beat holds its color
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) && $stable(blue))
    else $error("output beat changed while stalled");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // input side stalls only when the output register is held
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    1'b1 |-> (in_ready == (!out_valid || out_ready)))
    else $error("in_ready does not follow the output stall");

endmodule

bind hsl_to_rgb_converter hsl2rgb_port_checks u_hsl2rgb_port_checks (.*);
